FILE: rtl/set_assoc_lru_cache_sim_core_assert.svh
// Assertion macros used by the checker file.
`ifndef SET_ASSOC_LRU_CACHE_SIM_CORE_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_SIM_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SALC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SALC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/salc_pkg.sv
package salc_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int SETS         = 1 << MAX_SET_BITS;
    localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W       = WAY_W;
    localparam int SET_W        = MAX_SET_BITS;
    localparam int TAG_W        = 62;
    localparam int CNT_W        = 32;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_FETCH  = 2'd3;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;
    localparam logic [1:0] OUT_NONE  = 2'd3;

    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_WAYS_USED   = 2'd1;
    localparam logic [1:0] REG_OFFSET_BITS = 2'd2;

    typedef logic [TAG_W-1:0]  tag_t;
    typedef logic [RANK_W-1:0] rank_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;  // capture the accepted beat and read its set
        logic lookup;     // resolve the lookup and write the set back
        logic count_only; // first lookup outcome latch enable
    } salc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_modify;
        logic is_fetch;
        logic clearing;   // set rows are still being cleared after reset
    } salc_stat_t;

endpackage

FILE: rtl/salc_datapath.sv
module salc_datapath
    import salc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  salc_cmd_t              cmd,
    output salc_stat_t             stat,
    input  logic [1:0]             in_op,
    input  logic [63:0]            in_address,
    input  logic [2:0]             set_bits,
    input  logic [3:0]             ways_used,
    input  logic [4:0]             offset_bits,
    output logic [1:0]             outcome,
    output logic [CNT_W-1:0]       hits,
    output logic [CNT_W-1:0]       misses,
    output logic [CNT_W-1:0]       evictions
);

    // Per-set memories: one row holds all ways of a set.
    tag_t  tag_mem  [SETS][MAX_WAYS];
    rank_t rank_mem [SETS][MAX_WAYS];
    logic [MAX_WAYS-1:0] valid_mem [SETS];

    logic [1:0]        op_reg;
    tag_t              tag_reg;
    logic [SET_W-1:0]  set_reg;
    tag_t              rd_tag   [MAX_WAYS];
    rank_t             rd_rank  [MAX_WAYS];
    logic [MAX_WAYS-1:0] rd_valid;
    logic [1:0]        outcome_reg;
    logic [CNT_W-1:0]  hits_reg, misses_reg, evict_reg;
    logic [SET_W-1:0]  clr_idx_reg;
    logic              clr_busy_reg;

    logic [2:0]        sb;
    logic [4:0]        ob;
    logic [3:0]        nw;
    logic [5:0]        sh;
    logic [63:0]       shifted;
    tag_t              tag_c;
    logic [SET_W-1:0]  set_c;

    always_comb
    begin
        sb = (set_bits == 3'd0) ? 3'd1 :
             (set_bits > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits;
        ob = (offset_bits == 5'd0) ? 5'd1 : offset_bits;
        nw = (ways_used == 4'd0) ? 4'd1 :
             (ways_used > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : ways_used;
        shifted = in_address >> ob;
        set_c = shifted[SET_W-1:0] & SET_W'((1 << sb) - 1);
        sh = 6'(sb) + 6'(ob);
        tag_c = TAG_W'(in_address >> sh);
    end

    // Lookup logic on the registered row.
    logic [MAX_WAYS-1:0] hit_vec, inv_vec, in_use;
    logic                hit_any, inv_any;
    logic [WAY_W-1:0]    hit_way, inv_way, lru_way, sel_way;
    rank_t               best;
    rank_t               old_rank;
    logic                old_valid;
    logic [1:0]          res;

    always_comb
    begin
        hit_any = 1'b0;
        inv_any = 1'b0;
        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        best    = rd_rank[0];
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            in_use[w]  = (w < int'(nw));
            hit_vec[w] = in_use[w] && rd_valid[w] && (rd_tag[w] == tag_reg);
            inv_vec[w] = in_use[w] && !rd_valid[w];
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (inv_vec[w])
            begin
                inv_any = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (in_use[w] && rd_rank[w] > best)
            begin
                best    = rd_rank[w];
                lru_way = WAY_W'(w);
            end
        end
        if (hit_any)
        begin
            sel_way = hit_way;
            res     = OUT_HIT;
        end
        else if (inv_any)
        begin
            sel_way = inv_way;
            res     = OUT_FILL;
        end
        else
        begin
            sel_way = lru_way;
            res     = OUT_EVICT;
        end
        old_valid = rd_valid[sel_way];
        old_rank  = rd_rank[sel_way];
    end

    // New row contents after the lookup.
    rank_t             new_rank [MAX_WAYS];
    logic [MAX_WAYS-1:0] new_valid;

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            new_rank[w] = rd_rank[w];
            if (WAY_W'(w) == sel_way)
                new_rank[w] = '0;
            else if (rd_valid[w] && (!old_valid || rd_rank[w] < old_rank))
                new_rank[w] = rd_rank[w] + rank_t'(1);
        end
        new_valid = rd_valid;
        new_valid[sel_way] = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            // One set row is cleared per cycle after reset.
            valid_mem[clr_idx_reg] <= '0;
            for (int w = 0; w < MAX_WAYS; w++)
                rank_mem[clr_idx_reg][w] <= '0;
        end
        else if (cmd.load_item)
        begin
            op_reg   <= in_op;
            tag_reg  <= tag_c;
            set_reg  <= set_c;
            rd_valid <= valid_mem[set_c];
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                rd_tag[w]  <= tag_mem[set_c][w];
                rd_rank[w] <= rank_mem[set_c][w];
            end
        end
        else if (cmd.lookup)
        begin
            // Forward the written row for a second lookup of the same set.
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                rank_mem[set_reg][w] <= new_rank[w];
                rd_rank[w]           <= new_rank[w];
            end
            valid_mem[set_reg]        <= new_valid;
            rd_valid                  <= new_valid;
            tag_mem[set_reg][sel_way] <= tag_reg;
            rd_tag[sel_way]           <= tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
            outcome_reg  <= OUT_NONE;
            hits_reg     <= '0;
            misses_reg   <= '0;
            evict_reg    <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == SET_W'(SETS - 1))
                    clr_busy_reg <= 1'b0;
            end
            if (cmd.load_item)
            begin
                outcome_reg <= OUT_NONE;
            end
            else if (cmd.lookup)
            begin
                if (cmd.count_only)
                    outcome_reg <= res;
                if (res == OUT_HIT)
                    hits_reg <= hits_reg + 1'b1;
                else
                    misses_reg <= misses_reg + 1'b1;
                if (res == OUT_EVICT)
                    evict_reg <= evict_reg + 1'b1;
            end
        end
    end

    assign stat.is_modify = (op_reg == OP_MODIFY);
    assign stat.is_fetch  = (op_reg == OP_FETCH);
    assign stat.clearing  = clr_busy_reg;
    assign outcome   = outcome_reg;
    assign hits      = hits_reg;
    assign misses    = misses_reg;
    assign evictions = evict_reg;

endmodule

FILE: rtl/salc_ctrl.sv
module salc_ctrl
    import salc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  salc_stat_t stat,
    output salc_cmd_t  cmd
);

    typedef enum logic [1:0] {S_IDLE, S_LOOK1, S_LOOK2, S_DONE} state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !stat.clearing)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_LOOK1;
                end
            end
            S_LOOK1:
            begin
                if (stat.is_fetch)
                    state_next = S_DONE;
                else
                begin
                    cmd.lookup     = 1'b1;
                    cmd.count_only = 1'b1;
                    state_next     = stat.is_modify ? S_LOOK2 : S_DONE;
                end
            end
            S_LOOK2:
            begin
                cmd.lookup = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready  = (state_reg == S_IDLE) && !stat.clearing;
    assign out_valid = (state_reg == S_DONE);

endmodule

FILE: rtl/set_assoc_lru_cache_sim_core.sv
// Set-associative LRU cache simulator core.
// The slave stream takes one access per beat: tdata holds op in bits 1:0 and
// the 64-bit address in bits 65:2. The master stream returns one result per
// access: outcome, then the hit, miss and eviction totals.
// The configuration channel writes set_bits (index 0), ways_used (index 1)
// and offset_bits (index 2); write only while no access is in progress.
// One access runs in turn: the set row is read, then looked up (a second
// lookup follows for a modify; a fetch skips the lookup), then the result
// is held until taken. The next access is accepted the cycle after the
// result is taken. If the receiver stalls the result holds steady and no
// access is accepted. Reset clears the totals and restores the registers
// to 1; a pass after reset then clears the valid bits and ranks one set
// per cycle, and no access is accepted until it ends. Line tags are
// written on every lookup.
module set_assoc_lru_cache_sim_core
    import salc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // op[1:0], address[65:2]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // outcome, hits, misses, evictions
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [4:0]   cfg_data
);

    logic [2:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic [4:0] offset_reg;
    salc_cmd_t  cmd;
    salc_stat_t stat;
    logic [1:0] outcome;
    logic [CNT_W-1:0] hits, misses, evictions;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= 3'd1;
            ways_reg     <= 4'd1;
            offset_reg   <= 5'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SET_BITS:    set_bits_reg <= cfg_data[2:0];
                REG_WAYS_USED:   ways_reg     <= cfg_data[3:0];
                REG_OFFSET_BITS: offset_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    salc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    salc_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_op       (s_axis_tdata[1:0]),
        .in_address  (s_axis_tdata[65:2]),
        .set_bits    (set_bits_reg),
        .ways_used   (ways_reg),
        .offset_bits (offset_reg),
        .outcome     (outcome),
        .hits        (hits),
        .misses      (misses),
        .evictions   (evictions)
    );

    assign m_axis_tdata = {6'd0, evictions, misses, hits, outcome};

endmodule

FILE: rtl/salc_checker.sv
`include "set_assoc_lru_cache_sim_core_assert.svh"

module salc_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata
);

    // Only one access is in flight, so both sides are never open together.
    `SALC_ASSERT_IMPL(a_one_in_flight, clk, rst_n, m_axis_tvalid, !s_axis_tready)

    // A result that is taken frees the input side on the next cycle.
    `SALC_ASSERT_NEXT(a_ready_after_out, clk, rst_n,
        m_axis_tvalid && m_axis_tready, s_axis_tready)

    // An accepted beat closes the input side until its result is gone.
    `SALC_ASSERT_NEXT(a_busy_after_in, clk, rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A stalled result beat keeps its payload.
    `SALC_ASSERT_NEXT(a_hold, clk, rst_n,
        m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

endmodule

bind set_assoc_lru_cache_sim_core salc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: dv/set_assoc_lru_cache_sim_core_checker.sv
module set_assoc_lru_cache_sim_core_checker
    import salc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // op[1:0], address[65:2]
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,  // outcome[1:0], hits[33:2], misses[65:34], evictions[97:66]
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [4:0]   cfg_data,
    output int           fail_count,
    output int           pending,
    output int           access_count,
    output int           evict_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CNT_W-1:0] evictions;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] hits;
        logic [1:0]       outcome;
    } access_result_t;

    logic [2:0]       cur_set_bits;
    logic [3:0]       cur_ways;
    logic [4:0]       cur_offset_bits;
    logic             valid_q [SETS*MAX_WAYS];
    tag_t             tag_q   [SETS*MAX_WAYS];
    int unsigned      rank_q  [SETS*MAX_WAYS];
    logic [CNT_W-1:0] hit_cnt, miss_cnt, evict_cnt;
    access_result_t   expected_results [$];

    function automatic void promote_line(int base, int way);
        int unsigned prev;
        prev = valid_q[base+way] ? rank_q[base+way] : MAX_WAYS;
        for (int w = 0; w < MAX_WAYS; w++)
            if (w != way && valid_q[base+w] && rank_q[base+w] < prev)
                rank_q[base+w]++;
        rank_q[base+way] = 0;
        valid_q[base+way] = 1'b1;
    endfunction

    function automatic logic [1:0] cache_lookup(logic [63:0] addr);
        int sb, ob, nw, base, victim;
        int unsigned oldest;
        tag_t tag;
        logic [63:0] shifted;
        sb = (cur_set_bits < 1) ? 1 : (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS
                                                                       : cur_set_bits;
        ob = (cur_offset_bits < 1) ? 1 : cur_offset_bits;
        nw = (cur_ways < 1) ? 1 : (cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways;
        shifted = addr >> (sb + ob);
        tag = shifted[TAG_W-1:0];
        shifted = addr >> ob;
        base = int'(shifted & ((64'd1 << sb) - 1)) * MAX_WAYS;
        for (int w = 0; w < nw; w++)
            if (valid_q[base+w] && tag_q[base+w] == tag)
            begin
                hit_cnt++;
                promote_line(base, w);
                return OUT_HIT;
            end
        for (int w = 0; w < nw; w++)
            if (!valid_q[base+w])
            begin
                tag_q[base+w] = tag;
                promote_line(base, w);
                miss_cnt++;
                return OUT_FILL;
            end
        victim = 0;
        oldest = rank_q[base];
        for (int w = 1; w < nw; w++)
            if (rank_q[base+w] > oldest)
            begin
                oldest = rank_q[base+w];
                victim = w;
            end
        tag_q[base+victim] = tag;
        promote_line(base, victim);
        miss_cnt++;
        evict_cnt++;
        return OUT_EVICT;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        access_result_t r, got;
        logic [1:0] op;
        logic [63:0] addr;
        if (!rst_n)
        begin
            cur_set_bits = 1;
            cur_ways = 1;
            cur_offset_bits = 1;
            for (int i = 0; i < SETS*MAX_WAYS; i++)
            begin
                valid_q[i] = 0;
                tag_q[i] = '0;
                rank_q[i] = 0;
            end
            hit_cnt = 0;
            miss_cnt = 0;
            evict_cnt = 0;
            expected_results.delete();
            fail_count = 0;
            access_count = 0;
            evict_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_SET_BITS:    cur_set_bits = cfg_data[2:0];
                    REG_WAYS_USED:   cur_ways = cfg_data[3:0];
                    REG_OFFSET_BITS: cur_offset_bits = cfg_data;
                    default: ;
                endcase
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[97:0];
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: %h", got);
                    fail_count++;
                end
                else
                begin
                    r = expected_results.pop_front();
                    if (got.outcome !== r.outcome)
                    begin
                        $error("outcome: expected %0d, got %0d", r.outcome, got.outcome);
                        fail_count++;
                    end
                    if (got.hits !== r.hits)
                    begin
                        $error("hits_total: expected %0d, got %0d", r.hits, got.hits);
                        fail_count++;
                    end
                    if (got.misses !== r.misses)
                    begin
                        $error("misses_total: expected %0d, got %0d", r.misses, got.misses);
                        fail_count++;
                    end
                    if (got.evictions !== r.evictions)
                    begin
                        $error("evictions_total: expected %0d, got %0d",
                               r.evictions, got.evictions);
                        fail_count++;
                    end
                    if (got.outcome == OUT_EVICT)
                        evict_seen++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                op = s_axis_tdata[1:0];
                addr = s_axis_tdata[65:2];
                r.outcome = OUT_NONE;
                if (op == OP_LOAD || op == OP_STORE)
                    r.outcome = cache_lookup(addr);
                else if (op == OP_MODIFY)
                begin
                    r.outcome = cache_lookup(addr);
                    void'(cache_lookup(addr));
                end
                r.hits = hit_cnt;
                r.misses = miss_cnt;
                r.evictions = evict_cnt;
                expected_results.push_back(r);
                access_count++;
            end
        end
        pending = expected_results.size();
    end
endmodule

FILE: dv/set_assoc_lru_cache_sim_core_tb.sv
module set_assoc_lru_cache_sim_core_tb;
    import salc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;  // op[1:0], address[65:2]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;  // outcome[1:0], hits[33:2], misses[65:34], evictions[97:66]
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [4:0]   cfg_data;
    int           fail_count, pending, access_count, evict_seen;
    int           cycle_count;
    logic [63:0]  recent_addr [8];

    set_assoc_lru_cache_sim_core dut (.*);
    set_assoc_lru_cache_sim_core_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Receiver stalls in its own rhythm: long ready runs alternating with
    // longer stretches of random stalling.
    always @(posedge clk)
    begin
        if (cycle_count % 300 < 100)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 2) != 0);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic send_access(logic [1:0] op, logic [63:0] addr);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, addr, op};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drop_valid();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly reuses a small pool of addresses so sets fill, hit and evict.
    task automatic random_phase(int count);
        int burst;
        logic [63:0] addr;
        logic [1:0] op;
        foreach (recent_addr[i])
            recent_addr[i] = {$urandom, $urandom};
        while (count > 0)
        begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst && count > 0; i++, count--)
            begin
                case ($urandom_range(0, 9))
                    0: addr = {$urandom, $urandom};
                    1, 2: addr = {$urandom, $urandom} & 64'h3FFF;
                    default: addr = recent_addr[$urandom_range(0, 7)] ^ $urandom_range(0, 255);
                endcase
                if ($urandom_range(0, 7) == 0)
                    recent_addr[$urandom_range(0, 7)] = addr;
                op = $urandom_range(0, 3);
                send_access(op, addr);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        drop_valid();
    endtask

    initial
    begin
        logic [4:0] sb_vals [6] = '{5'd1, 5'd6, 5'd0, 5'd7, 5'd3, 5'd2};
        logic [4:0] wy_vals [6] = '{5'd1, 5'd8, 5'd0, 5'd15, 5'd4, 5'd2};
        logic [4:0] ob_vals [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd20};
        rst_n = 0;
        cycle_count = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        cfg_valid = 0;
        cfg_index = REG_SET_BITS;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: field extremes, every op, refills and eviction at reset config.
        send_access(OP_LOAD, 64'd0);
        send_access(OP_LOAD, 64'd0);
        send_access(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(OP_MODIFY, 64'h5555_5555_5555_5555);
        send_access(OP_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
        send_access(OP_FETCH, 64'h1234);
        send_access(OP_LOAD, 64'd4);
        send_access(OP_LOAD, 64'd8);
        send_access(OP_LOAD, 64'd0);
        drop_valid();
        wait_idle();
        write_reg(REG_WAYS_USED, 5'd2);
        send_access(OP_LOAD, 64'd0);
        send_access(OP_LOAD, 64'd16);
        send_access(OP_LOAD, 64'd32);
        send_access(OP_LOAD, 64'd0);
        drop_valid();
        // Shrinking the ways leaves lines beyond them untouched; a duplicate
        // tag may later appear across ways.
        wait_idle();
        write_reg(REG_WAYS_USED, 5'd1);
        send_access(OP_LOAD, 64'd32);
        drop_valid();
        wait_idle();
        write_reg(REG_WAYS_USED, 5'd2);
        send_access(OP_LOAD, 64'd32);
        drop_valid();

        for (int phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            write_reg(REG_SET_BITS, sb_vals[phase]);
            write_reg(REG_WAYS_USED, wy_vals[phase]);
            write_reg(REG_OFFSET_BITS, ob_vals[phase]);
            random_phase(300);
        end
        wait_idle();
        if (cycle_count >= 0)
            repeat (10) @(posedge clk);
        $display("Ran %0d accesses over six cache geometries, %0d evicting.",
                 access_count, evict_seen);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
